// File: rtl/tbd_pkg.sv
`default_nettype none
package tbd_pkg;

  typedef enum logic [3:0] {
    FMT_BC1      = 4'd0,
    FMT_BC1_TR   = 4'd1,
    FMT_BC2      = 4'd2,
    FMT_BC3      = 4'd3,
    FMT_BC4      = 4'd4,
    FMT_BC5      = 4'd5,
    FMT_ATC      = 4'd6,
    FMT_ATC_EXP  = 4'd7,
    FMT_ATC_INT  = 4'd8
  } fmt_e;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Per-texel work handed from the block register to the texel pipeline
  typedef struct packed {
    logic [3:0]  fmt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [3:0]  idx;
  } texel_req_t;

  function automatic logic [7:0] ext5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] ext6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // Truncating divide by 3 of a value below 766
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[18:11];
  endfunction

  // Truncating divide by 7 of a value below 1786
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd2341;
    return p[21:14];
  endfunction

  // Truncating divide by 5 of a value below 1276
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'd3277;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

// File: rtl/tbd_texel_pipe.sv
`default_nettype none
module tbd_texel_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire tbd_pkg::texel_req_t in_req_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [3:0]              texel_index_o,
  output logic [7:0]              chan_red_o,
  output logic [7:0]              chan_green_o,
  output logic [7:0]              chan_blue_o,
  output logic [7:0]              chan_alpha_o,
  output logic [2:0]              channels_written_o,
  output logic                    last_texel_o
);
  import tbd_pkg::*;

  logic adv;
  assign adv = !out_stall_i || !out_valid_o;
  assign in_stall_o = !adv;

  // Stage 1: decode endpoints, select codes
  logic        v1_q;
  logic [3:0]  fmt1_q, idx1_q;
  logic [7:0]  e0_q [3], e1_q [3];
  logic [7:0]  a0_q, a1_q, b0_q, b1_q;
  logic [1:0]  ci1_q;
  logic [2:0]  sa1_q, sb1_q;
  logic [3:0]  ea1_q;
  logic        four1_q, atcneg1_q;

  logic [63:0] csrc, lo, hi;
  logic [15:0] c0, c1;
  logic [3:0]  f0, ix;
  logic        is_atc, use_hi;
  always_comb begin
    f0 = in_req_i.fmt;
    lo = in_req_i.lo;
    hi = in_req_i.hi;
    ix = in_req_i.idx;
    is_atc = (f0 == FMT_ATC) || (f0 == FMT_ATC_EXP) || (f0 == FMT_ATC_INT);
    use_hi = !(f0 == FMT_BC1 || f0 == FMT_BC1_TR || f0 == FMT_ATC);
    csrc = use_hi ? hi : lo;
    c0 = csrc[15:0];
    c1 = csrc[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fmt1_q <= f0;
      idx1_q <= ix;
      if (is_atc) begin
        e0_q[0] <= ext5(c0[14:10]);
        e0_q[1] <= ext5(c0[9:5]);
        e0_q[2] <= ext5(c0[4:0]);
      end else begin
        e0_q[0] <= ext5(c0[15:11]);
        e0_q[1] <= ext6(c0[10:5]);
        e0_q[2] <= ext5(c0[4:0]);
      end
      e1_q[0] <= ext5(c1[15:11]);
      e1_q[1] <= ext6(c1[10:5]);
      e1_q[2] <= ext5(c1[4:0]);
      four1_q <= (c0 > c1) || f0 == FMT_BC2 || f0 == FMT_BC3;
      atcneg1_q <= c0[15];
      ci1_q <= 2'(csrc >> (6'd32 + {ix, 1'b0}));
      sa1_q <= 3'(lo >> (7'd16 + 7'(ix) * 7'd3));
      sb1_q <= 3'(hi >> (7'd16 + 7'(ix) * 7'd3));
      ea1_q <= 4'(lo >> {ix, 2'b00});
      a0_q <= lo[7:0];
      a1_q <= lo[15:8];
      b0_q <= hi[7:0];
      b1_q <= hi[15:8];
    end
  end

  // Stage 2: interpolate the selected palette entry and alpha entries
  logic        v2_q;
  logic [3:0]  fmt2_q, idx2_q;
  logic [7:0]  col2_q [3];
  logic [7:0]  ca2_q, ra2_q, rb2_q, ea2_q;

  function automatic logic [7:0] interp_a(input logic [7:0] x0, input logic [7:0] x1,
                                          input logic [2:0] s);
    logic [10:0] w0, w1;
    logic [7:0]  r;
    w0 = 11'd0;
    w1 = 11'd0;
    r = 8'd0;
    if (s == 3'd0) r = x0;
    else if (s == 3'd1) r = x1;
    else if (x0 > x1) begin
      w0 = 11'(4'd8 - 4'(s)) * 11'(x0);
      w1 = 11'(4'(s) - 4'd1) * 11'(x1);
      r = div7(w0 + w1);
    end else if (s == 3'd6) r = 8'd0;
    else if (s == 3'd7) r = 8'hff;
    else begin
      w0 = 11'(4'd6 - 4'(s)) * 11'(x0);
      w1 = 11'(4'(s) - 4'd1) * 11'(x1);
      r = div5(w0 + w1);
    end
    return r;
  endfunction

  logic [7:0] col [3];
  logic [7:0] cal;
  always_comb begin
    cal = ALPHA_OPAQUE;
    for (int c = 0; c < 3; c++) begin
      col[c] = 8'd0;
      if (fmt1_q == FMT_ATC || fmt1_q == FMT_ATC_EXP || fmt1_q == FMT_ATC_INT) begin
        if (atcneg1_q) begin
          case (ci1_q)
            2'd0:    col[c] = 8'd0;
            2'd1:    col[c] = e0_q[c] - {2'b00, e1_q[c][7:2]};
            2'd2:    col[c] = e0_q[c];
            default: col[c] = e1_q[c];
          endcase
        end else begin
          case (ci1_q)
            2'd0:    col[c] = e0_q[c];
            2'd1:    col[c] = div3({1'b0, e0_q[c], 1'b0} + 10'(e1_q[c]));
            2'd2:    col[c] = div3(10'(e0_q[c]) + {1'b0, e1_q[c], 1'b0});
            default: col[c] = e1_q[c];
          endcase
        end
      end else begin
        case (ci1_q)
          2'd0: col[c] = e0_q[c];
          2'd1: col[c] = e1_q[c];
          2'd2: col[c] = four1_q ? div3({1'b0, e0_q[c], 1'b0} + 10'(e1_q[c]))
                                 : 8'((9'(e0_q[c]) + 9'(e1_q[c])) >> 1);
          default: col[c] = four1_q ? div3(10'(e0_q[c]) + {1'b0, e1_q[c], 1'b0}) : 8'd0;
        endcase
      end
    end
    if (ci1_q == 2'd3 && !four1_q && fmt1_q == FMT_BC1_TR) cal = 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fmt2_q <= fmt1_q;
      idx2_q <= idx1_q;
      col2_q <= col;
      ca2_q  <= cal;
      ra2_q  <= interp_a(a0_q, a1_q, sa1_q);
      rb2_q  <= interp_a(b0_q, b1_q, sb1_q);
      ea2_q  <= {ea1_q, ea1_q};
    end
  end

  // Stage 3: route per format into the output word
  logic [7:0] r3, g3, b3, a3;
  logic [2:0] n3;
  always_comb begin
    r3 = 8'd0; g3 = 8'd0; b3 = 8'd0; a3 = 8'd0; n3 = 3'd4;
    case (fmt2_q)
      FMT_BC1, FMT_BC1_TR, FMT_ATC: begin
        r3 = col2_q[0]; g3 = col2_q[1]; b3 = col2_q[2]; a3 = ca2_q;
      end
      FMT_BC2, FMT_ATC_EXP: begin
        r3 = col2_q[0]; g3 = col2_q[1]; b3 = col2_q[2]; a3 = ea2_q;
      end
      FMT_BC3, FMT_ATC_INT: begin
        r3 = col2_q[0]; g3 = col2_q[1]; b3 = col2_q[2]; a3 = ra2_q;
      end
      FMT_BC4: begin
        r3 = ra2_q; n3 = 3'd1;
      end
      FMT_BC5: begin
        r3 = ra2_q; g3 = rb2_q; n3 = 3'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      texel_index_o      <= idx2_q;
      chan_red_o         <= r3;
      chan_green_o       <= g3;
      chan_blue_o        <= b3;
      chan_alpha_o       <= a3;
      channels_written_o <= n3;
      last_texel_o       <= (idx2_q == 4'd15);
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(texel_index_o))
    else $error("texel word changed under stall");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_texel_o == (texel_index_o == 4'd15)))
    else $error("last flag mismatch");
  a_nch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channels_written_o == 3'd1 |-> chan_green_o == 8'd0)
    else $error("bc4 green not zero");
`endif
endmodule
`default_nettype wire

// File: rtl/texture_block_decompressor_top.sv
// The first texel word of a block is registered in the block register, then stage 1, stage 2 and the output register.
// Throughput: one texel word per cycle while out_stall_i is low, 16 words per block; the block
// register takes the next block while the last texel of the previous one issues.
// Three-stage texel pipeline: endpoint decode, interpolation, format routing.
// Reset (async, active low) clears valid flags, texel counter and format (bc1).
`default_nettype none
module texture_block_decompressor_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] block_low_i,
  input  wire logic [63:0] block_high_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       texel_index_o,
  output logic [7:0]       chan_red_o,
  output logic [7:0]       chan_green_o,
  output logic [7:0]       chan_blue_o,
  output logic [7:0]       chan_alpha_o,
  output logic [2:0]       channels_written_o,
  output logic             last_texel_o
);
  import tbd_pkg::*;

  logic [3:0]  fmt_q;
  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [63:0] lo_q, hi_q;
  logic        pipe_stall;
  texel_req_t  req;
  logic        issue, take;

  assign issue = busy_q && !pipe_stall;
  assign in_stall_o = busy_q && !(issue && cnt_q == 4'd15);
  assign take = in_valid_i && !in_stall_o;

  // Hold format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BC1;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // Advance the texel counter across the held block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      if (issue) cnt_q <= cnt_q + 4'd1;
      if (take) busy_q <= 1'b1;
      else if (issue && cnt_q == 4'd15) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lo_q <= block_low_i;
      hi_q <= block_high_i;
    end
  end

  assign req = '{fmt: fmt_q, lo: lo_q, hi: hi_q, idx: cnt_q};

  tbd_texel_pipe u_pipe (
    .clk_i, .rst_ni,
    .in_valid_i (busy_q),
    .in_req_i   (req),
    .in_stall_o (pipe_stall),
    .out_valid_o, .out_stall_i,
    .texel_index_o, .chan_red_o, .chan_green_o, .chan_blue_o, .chan_alpha_o,
    .channels_written_o, .last_texel_o
  );

`ifndef SYNTHESIS
  a_cnt0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 4'd0)
    else $error("counter not parked at zero");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> busy_q && cnt_q == 4'd0)
    else $error("block not started at texel zero");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 4'd15 |-> in_stall_o)
    else $error("block taken mid-issue");
`endif
endmodule
`default_nettype wire
